// ===== rtl/core/vctb_pkg.sv =====
package vctb_pkg;

  // Bank size and fixed field widths.
  localparam int NUM_TIMERS = 4;
  localparam int OP_W       = 2;
  localparam int TIDX_W     = 2;
  localparam int TICK_W     = 24;
  localparam int COUNT_W    = 26;
  localparam int NPT_W      = 10;
  localparam int MASK_W     = 4;
  localparam int TIME_W     = 35;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // A start value of zero loads the full count.
  localparam logic [TICK_W-1:0] FULL_COUNT = 24'hFF_FFFF;

  // Lowest value a current count may hold, in the wide advance arithmetic.
  localparam logic signed [COUNT_W:0] COUNT_FLOOR = -27'sd16777216;

  localparam logic [NPT_W-1:0] NPT_RESET = 10'd20;

  // Operation codes of the input channel.
  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE = 2'd0,
    OP_START   = 2'd1,
    OP_STOP    = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NANOS_PER_TICK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_MASK  = 1'b1;

  // Command broadcast to every timer slot.
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [TICK_W-1:0] start_value;
    logic [TICK_W-1:0] elapsed_ticks;
  } cmd_t;

  // State of one timer slot, seen by the read path.
  typedef struct packed {
    logic               enabled;
    logic [TICK_W-1:0]  start;
    logic [COUNT_W-1:0] current;
  } slot_status_t;

endpackage

// ===== rtl/core/vctb_in_if.sv =====
interface vctb_in_if;
  logic                          valid;
  logic                          ready;
  logic [vctb_pkg::OP_W-1:0]     operation;
  logic [vctb_pkg::TIDX_W-1:0]   timer_index;
  logic [vctb_pkg::TICK_W-1:0]   start_value;
  logic [vctb_pkg::TICK_W-1:0]   elapsed_ticks;

  modport source (output valid, operation, timer_index, start_value, elapsed_ticks,
                  input ready);
  modport sink (input valid, operation, timer_index, start_value, elapsed_ticks,
                output ready);
endinterface

// ===== rtl/core/vctb_out_if.sv =====
interface vctb_out_if;
  logic                          valid;
  logic                          ready;
  logic [vctb_pkg::TIME_W-1:0]   elapsed_time;

  modport source (output valid, elapsed_time, input ready);
  modport sink (input valid, elapsed_time, output ready);
endinterface

// ===== rtl/core/vctb_slot.sv =====
module vctb_slot (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vctb_pkg::cmd_t         cmd,
  input  logic                   sel,
  input  logic                   periodic,
  output vctb_pkg::slot_status_t status
);

  logic [vctb_pkg::COUNT_W-1:0] cur_r, cur_nxt;
  logic [vctb_pkg::TICK_W-1:0]  start_r, start_nxt;
  logic                         en_r, en_nxt;

  logic signed [vctb_pkg::COUNT_W:0] diff;
  logic signed [vctb_pkg::COUNT_W:0] adj;
  logic [vctb_pkg::TICK_W-1:0]       load_val;

  // Advance: subtract, then reload or clamp on expiry, then saturate at the floor.
  always_comb begin
    diff = $signed({cur_r[vctb_pkg::COUNT_W-1], cur_r}) - $signed({3'b000, cmd.elapsed_ticks});
    adj  = diff;
    if (diff <= 0) begin
      if (periodic) begin
        adj = diff + $signed({3'b000, start_r});
      end else begin
        adj = '0;
      end
    end
    if (adj < vctb_pkg::COUNT_FLOOR) begin
      adj = vctb_pkg::COUNT_FLOOR;
    end
  end

  assign load_val = (cmd.start_value == '0) ? vctb_pkg::FULL_COUNT : cmd.start_value;

  // Next state for the accepted transaction.
  always_comb begin
    cur_nxt   = cur_r;
    start_nxt = start_r;
    en_nxt    = en_r;
    if (cmd.valid) begin
      case (cmd.op)
        vctb_pkg::OP_ADVANCE: begin
          if (en_r) begin
            cur_nxt = adj[vctb_pkg::COUNT_W-1:0];
          end
        end
        vctb_pkg::OP_START: begin
          if (sel) begin
            en_nxt    = 1'b1;
            start_nxt = load_val;
            cur_nxt   = {2'b00, load_val};
          end
        end
        vctb_pkg::OP_STOP: begin
          if (sel) begin
            en_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      start_r <= '0;
      en_r    <= 1'b0;
    end else begin
      cur_r   <= cur_nxt;
      start_r <= start_nxt;
      en_r    <= en_nxt;
    end
  end

  assign status.enabled = en_r;
  assign status.start   = start_r;
  assign status.current = cur_r;

endmodule

// ===== rtl/core/virtual_countdown_timer_bank_core.sv =====
// Bank of four virtual countdown timers.
// Input channel (in_chan): one transaction per operation: advance, start, stop
// or read. Advance subtracts elapsed_ticks from every enabled timer; start
// loads and enables the addressed timer; stop freezes it. Only a read makes a
// result transaction on out_chan, carrying (start - current) * nanos_per_tick.
// Configuration (cfg_we, cfg_index, cfg_wdata) sets nanos_per_tick and the
// periodic mask; write it only while the bank is idle.
// Throughput is one transaction per cycle while in_chan.ready is high: all timer
// slots update in parallel in the cycle of acceptance. A read result is registered
// into the output register, or into the skid register when the output register
// still waits; the read path is a slot mux, a subtract and a 26 x 10 multiply.
// A two-entry output buffer (output register plus skid register) keeps the
// input open while one result waits; in_chan.ready drops only when both hold
// results, and rises again as soon as the receiver takes one.
// Synchronous reset clears all counts, start values and enables, sets
// nanos_per_tick to 20 and makes every timer one-shot.
module virtual_countdown_timer_bank_core (
  input  logic                               clk,
  input  logic                               rst_n,
  vctb_in_if.sink                            in_chan,
  vctb_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [vctb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vctb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [vctb_pkg::NPT_W-1:0]  npt_r;
  logic [vctb_pkg::MASK_W-1:0] mask_r;

  logic                           in_acc;
  logic                           is_read;
  logic                           idx_valid;
  logic [vctb_pkg::NUM_TIMERS-1:0] sel;
  vctb_pkg::cmd_t                 cmd;
  vctb_pkg::slot_status_t         status [vctb_pkg::NUM_TIMERS];
  vctb_pkg::slot_status_t         rd_status;

  logic signed [vctb_pkg::COUNT_W:0] rd_diff;
  logic [vctb_pkg::COUNT_W-1:0]      rd_ticks;
  logic [35:0]                       rd_prod;
  logic [vctb_pkg::TIME_W-1:0]       rd_time;

  logic                         out_valid_r, out_valid_nxt;
  logic [vctb_pkg::TIME_W-1:0]  out_data_r, out_data_nxt;
  logic                         skid_valid_r, skid_valid_nxt;
  logic [vctb_pkg::TIME_W-1:0]  skid_data_r, skid_data_nxt;
  logic                         pop;
  logic                         push;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npt_r  <= vctb_pkg::NPT_RESET;
      mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vctb_pkg::CFG_NANOS_PER_TICK: npt_r  <= cfg_wdata[vctb_pkg::NPT_W-1:0];
        vctb_pkg::CFG_PERIODIC_MASK:  mask_r <= cfg_wdata[vctb_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input handshake and command decode.
  assign in_chan.ready = !skid_valid_r;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_read       = (in_chan.operation == vctb_pkg::OP_READ);
  assign idx_valid     = int'(in_chan.timer_index) < vctb_pkg::NUM_TIMERS;

  assign cmd.valid         = in_acc;
  assign cmd.op            = vctb_pkg::op_e'(in_chan.operation);
  assign cmd.start_value   = in_chan.start_value;
  assign cmd.elapsed_ticks = in_chan.elapsed_ticks;

  // Timer slots; only the first four can be periodic.
  for (genvar i = 0; i < vctb_pkg::NUM_TIMERS; i++) begin : g_slot
    logic periodic;
    if (i < vctb_pkg::MASK_W) begin : g_per
      assign periodic = mask_r[i];
    end else begin : g_oneshot
      assign periodic = 1'b0;
    end

    assign sel[i] = idx_valid && (int'(in_chan.timer_index) == i);

    vctb_slot u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (sel[i]),
      .periodic (periodic),
      .status   (status[i])
    );
  end

  // Read path: select the addressed slot, clamp the difference, scale.
  always_comb begin
    rd_status = '0;
    for (int i = 0; i < vctb_pkg::NUM_TIMERS; i++) begin
      if (sel[i]) begin
        rd_status = status[i];
      end
    end
  end

  always_comb begin
    rd_diff  = $signed({3'b000, rd_status.start})
             - $signed({rd_status.current[vctb_pkg::COUNT_W-1], rd_status.current});
    rd_ticks = rd_diff[vctb_pkg::COUNT_W] ? '0 : rd_diff[vctb_pkg::COUNT_W-1:0];
    rd_prod  = {10'b0, rd_ticks} * {26'b0, npt_r};
    rd_time  = idx_valid ? rd_prod[vctb_pkg::TIME_W-1:0] : '0;
  end

  // Output register with skid register behind it.
  assign pop  = out_valid_r && out_chan.ready;
  assign push = in_acc && is_read;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt = push;
      if (push) begin
        out_data_nxt = rd_time;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = rd_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.elapsed_time = out_data_r;

  // The skid register only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  // After an accepted read the output register always holds a result the next cycle.
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_read) |=> out_valid_r)
    else $error("accepted read produced no result");

  // Timer 0, while disabled, keeps its count unless it is started.
  a_stopped_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!status[0].enabled && !(in_acc && sel[0]
      && in_chan.operation == vctb_pkg::OP_START)) |=> $stable(status[0].current))
    else $error("count of a disabled timer changed");

endmodule

// ===== tb/virtual_countdown_timer_bank_core_tb.sv =====
`timescale 1ns / 1ps

module virtual_countdown_timer_bank_core_tb;

  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int NUM_PHASES  = 6;
  localparam int BURST_READS = 24;
  localparam int DIR_ROWS    = 24;
  localparam int DIR_SPLIT   = 16;

  // A full count read back at the reset scale of 20 ns per tick.
  localparam logic [vctb_pkg::TIME_W-1:0] FULL_AT_RESET_SCALE = 35'd335544300;

  // One operation on the input channel.
  typedef struct packed {
    vctb_pkg::op_e               op;
    logic [vctb_pkg::TIDX_W-1:0] idx;
    logic [vctb_pkg::TICK_W-1:0] start_value;
    logic [vctb_pkg::TICK_W-1:0] elapsed;
  } timer_op_t;

  // A directed row carries a typed result where it is obvious by inspection.
  typedef struct packed {
    timer_op_t                   item;
    logic                        typed;
    logic [vctb_pkg::TIME_W-1:0] time_ns;
  } dir_row_t;

  typedef struct packed {
    logic                        typed;
    logic [vctb_pkg::TIME_W-1:0] time_ns;
  } typed_note_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [vctb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vctb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  vctb_in_if  in_if();
  vctb_out_if out_if();

  virtual_countdown_timer_bank_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted timer state and configuration.
  logic [vctb_pkg::NPT_W-1:0]          npt_model;
  logic [vctb_pkg::MASK_W-1:0]         periodic_model;
  logic signed [vctb_pkg::COUNT_W-1:0] count_now   [vctb_pkg::NUM_TIMERS];
  logic [vctb_pkg::TICK_W-1:0]         count_start [vctb_pkg::NUM_TIMERS];
  logic                                timer_on    [vctb_pkg::NUM_TIMERS];

  logic [vctb_pkg::TIME_W-1:0] elapsed_time_q [$];
  typed_note_t                 note_q [$];

  int fail_count   = 0;
  int quiet_cycles = 0;
  int in_max_gap   = 8;
  int out_max_stall = 8;
  bit hold_req     = 1'b0;

  // Directed rows: reset configuration first, then periodic at 1000 ns per tick.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{vctb_pkg::OP_READ,    2'd0, 24'd0, 24'd0}, 1'b1, 35'd0},
    '{'{vctb_pkg::OP_START,   2'd0, 24'd0, 24'd0}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_READ,    2'd0, 24'd0, 24'd0}, 1'b1, 35'd0},
    '{'{vctb_pkg::OP_ADVANCE, 2'd0, 24'd0, 24'd16}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_READ,    2'd0, 24'd0, 24'd0}, 1'b1, 35'd320},
    '{'{vctb_pkg::OP_START,   2'd1, vctb_pkg::FULL_COUNT, 24'd0}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_START,   2'd2, 24'd1, 24'd0}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_ADVANCE, 2'd3, 24'd0, vctb_pkg::FULL_COUNT}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_READ,    2'd0, vctb_pkg::FULL_COUNT, vctb_pkg::FULL_COUNT},
      1'b1, FULL_AT_RESET_SCALE},
    '{'{vctb_pkg::OP_STOP,    2'd1, 24'd0, 24'd0}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_START,   2'd3, 24'd100, vctb_pkg::FULL_COUNT}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_ADVANCE, 2'd0, 24'd0, 24'd30}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_READ,    2'd3, 24'd0, 24'd0}, 1'b1, 35'd600},
    '{'{vctb_pkg::OP_READ,    2'd1, 24'd0, 24'd0}, 1'b1, FULL_AT_RESET_SCALE},
    '{'{vctb_pkg::OP_START,   2'd3, 24'd50, 24'd0}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_READ,    2'd3, 24'd0, 24'd0}, 1'b1, 35'd0},
    '{'{vctb_pkg::OP_START,   2'd0, 24'd1, 24'd0}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_ADVANCE, 2'd0, 24'd0, vctb_pkg::FULL_COUNT}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_ADVANCE, 2'd0, 24'd0, vctb_pkg::FULL_COUNT}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_READ,    2'd0, 24'd0, 24'd0}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_START,   2'd2, 24'd10, 24'd0}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_ADVANCE, 2'd0, 24'd0, 24'd10}, 1'b0, 35'd0},
    '{'{vctb_pkg::OP_READ,    2'd2, 24'd0, 24'd0}, 1'b1, 35'd0},
    '{'{vctb_pkg::OP_READ,    2'd3, 24'd0, 24'd0}, 1'b0, 35'd0}
  };

  // Settings of the random phases; the last scale is drawn at run time.
  logic [vctb_pkg::NPT_W-1:0]  phase_npt  [NUM_PHASES] =
    '{10'd1000, 10'd0, 10'd1, 10'd1023, 10'd20, 10'd500};
  logic [vctb_pkg::MASK_W-1:0] phase_mask [NUM_PHASES] =
    '{4'hF, 4'h5, 4'hA, 4'h0, 4'h3, 4'h6};

  // Applies one operation to the predicted bank; returns 1 when it yields a read result.
  function automatic logic step_timers(input timer_op_t t,
                                       output logic [vctb_pkg::TIME_W-1:0] read_ns);
    longint                      c;
    longint                      span;
    logic [vctb_pkg::TICK_W-1:0] load;
    logic                        in_range;
    read_ns     = '0;
    step_timers = 1'b0;
    in_range    = int'(t.idx) < vctb_pkg::NUM_TIMERS;
    case (t.op)
      vctb_pkg::OP_ADVANCE: begin
        for (int i = 0; i < vctb_pkg::NUM_TIMERS; i++) begin
          if (timer_on[i]) begin
            c = longint'(count_now[i]) - longint'(t.elapsed);
            // Expiry reloads a periodic timer once and clamps a one-shot timer.
            if (c <= 0) begin
              c = periodic_model[i] ? c + longint'(count_start[i]) : 0;
            end
            if (c < longint'(vctb_pkg::COUNT_FLOOR)) begin
              c = longint'(vctb_pkg::COUNT_FLOOR);
            end
            count_now[i] = c[vctb_pkg::COUNT_W-1:0];
          end
        end
      end
      vctb_pkg::OP_START: begin
        if (in_range) begin
          load = (t.start_value == '0) ? vctb_pkg::FULL_COUNT : t.start_value;
          timer_on[t.idx]    = 1'b1;
          count_start[t.idx] = load;
          count_now[t.idx]   = {{(vctb_pkg::COUNT_W-vctb_pkg::TICK_W){1'b0}}, load};
        end
      end
      vctb_pkg::OP_STOP: begin
        if (in_range) begin
          timer_on[t.idx] = 1'b0;
        end
      end
      default: begin
        if (in_range) begin
          span = longint'(count_start[t.idx]) - longint'(count_now[t.idx]);
          if (span < 0) begin
            span = 0;
          end
          c = span * longint'(npt_model);
          read_ns = c[vctb_pkg::TIME_W-1:0];
        end
        step_timers = 1'b1;
      end
    endcase
  endfunction

  // Random operation, weighted toward advance and read with mostly small tick values.
  function automatic timer_op_t random_op();
    timer_op_t   t;
    int          pick;
    logic [31:0] draw;
    pick = $urandom_range(0, 19);
    if (pick < 7) begin
      t.op = vctb_pkg::OP_ADVANCE;
    end else if (pick < 11) begin
      t.op = vctb_pkg::OP_START;
    end else if (pick < 13) begin
      t.op = vctb_pkg::OP_STOP;
    end else begin
      t.op = vctb_pkg::OP_READ;
    end
    draw  = $urandom_range(0, vctb_pkg::NUM_TIMERS - 1);
    t.idx = draw[vctb_pkg::TIDX_W-1:0];
    case ($urandom_range(0, 9))
      0:       draw = '0;
      1:       draw = {8'h00, vctb_pkg::FULL_COUNT};
      2, 3, 4, 5: draw = $urandom_range(1, 200);
      6, 7:    draw = $urandom_range(1, 5000);
      default: draw = $urandom();
    endcase
    t.start_value = draw[vctb_pkg::TICK_W-1:0];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: draw = $urandom_range(0, 20);
      4, 5:    draw = $urandom_range(0, 300);
      6:       draw = '0;
      7:       draw = {8'h00, vctb_pkg::FULL_COUNT};
      default: draw = $urandom();
    endcase
    t.elapsed = draw[vctb_pkg::TICK_W-1:0];
    return t;
  endfunction

  // Offers one operation after a random gap and returns at the edge that accepts it.
  task automatic send_op(input timer_op_t t, input logic typed,
                         input logic [vctb_pkg::TIME_W-1:0] time_ns);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note_q.push_back('{typed, time_ns});
    in_if.valid         <= 1'b1;
    in_if.operation     <= t.op;
    in_if.timer_index   <= t.idx;
    in_if.start_value   <= t.start_value;
    in_if.elapsed_ticks <= t.elapsed;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Lets the bank go idle: every offered transaction taken and every result returned.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (note_q.size() != 0 || elapsed_time_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; only called while the bank is idle.
  task automatic load_config(input logic [vctb_pkg::NPT_W-1:0] npt,
                             input logic [vctb_pkg::MASK_W-1:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= vctb_pkg::CFG_NANOS_PER_TICK;
    cfg_wdata <= vctb_pkg::CFG_DATA_W'(npt);
    @(posedge clk);
    cfg_index <= vctb_pkg::CFG_PERIODIC_MASK;
    cfg_wdata <= vctb_pkg::CFG_DATA_W'(mask);
    @(posedge clk);
    cfg_we <= 1'b0;
    npt_model      = npt;
    periodic_model = mask;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Checks each result transaction and predicts each accepted input transaction.
  always @(posedge clk) begin : check_and_predict
    typed_note_t                 note;
    timer_op_t                   seen;
    logic [vctb_pkg::TIME_W-1:0] want;
    logic [vctb_pkg::TIME_W-1:0] predicted;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (elapsed_time_q.size() == 0) begin
          $error("elapsed_time: expected no result, actual %0d", out_if.elapsed_time);
          fail_count++;
        end else begin
          want = elapsed_time_q.pop_front();
          if (out_if.elapsed_time !== want) begin
            $error("elapsed_time: expected %0d, actual %0d", want, out_if.elapsed_time);
            fail_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        note             = note_q.pop_front();
        seen.op          = vctb_pkg::op_e'(in_if.operation);
        seen.idx         = in_if.timer_index;
        seen.start_value = in_if.start_value;
        seen.elapsed     = in_if.elapsed_ticks;
        if (step_timers(seen, predicted)) begin
          elapsed_time_q.push_back(note.typed ? note.time_ns : predicted);
        end
      end
    end
  end

  // Ends the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: a random stall per transaction, or one long hold-off on request.
  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, out_max_stall);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Reset, directed rows, then random phases under changing settings.
  initial begin : stimulus
    timer_op_t   t;
    logic [31:0] draw;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    in_if.valid         <= 1'b0;
    in_if.operation     <= '0;
    in_if.timer_index   <= '0;
    in_if.start_value   <= '0;
    in_if.elapsed_ticks <= '0;
    npt_model      = vctb_pkg::NPT_RESET;
    periodic_model = '0;
    for (int i = 0; i < vctb_pkg::NUM_TIMERS; i++) begin
      count_now[i]   = '0;
      count_start[i] = '0;
      timer_on[i]    = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (r == DIR_SPLIT) begin
        wait_idle();
        load_config(10'd1000, 4'hF);
      end
      send_op(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].time_ns);
    end
    wait_idle();

    draw = $urandom_range(1, 1000);
    phase_npt[NUM_PHASES-1]  = draw[vctb_pkg::NPT_W-1:0];
    draw = $urandom();
    phase_mask[NUM_PHASES-1] = draw[vctb_pkg::MASK_W-1:0];
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_config(phase_npt[p], phase_mask[p]);
      in_max_gap    = (p == 1 || p == 4) ? 0 : 8;
      out_max_stall = (p == 2 || p == 4) ? 0 : 8;
      // A burst of reads against a held-off receiver fills the output buffer.
      if (p == 2) begin
        in_max_gap = 0;
        hold_req   = 1'b1;
        for (int k = 0; k < BURST_READS; k++) begin
          t    = random_op();
          t.op = vctb_pkg::OP_READ;
          send_op(t, 1'b0, '0);
        end
        in_max_gap = 8;
      end
      repeat (PHASE_ITEMS) send_op(random_op(), 1'b0, '0);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
